@@ src/qpn_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the quad panel normal/area/tangent unit.
// No dependencies; every other file in src uses it by scoped names.
package qpn_pkg;

    localparam int CoordW    = 32;
    localparam int PcW       = 17;
    localparam int IdxW      = 16;
    localparam int MaxPanels = 65536;
    localparam int QDepth    = 2;
    localparam int PtrW      = $clog2(QDepth);
    localparam int QCntW     = $clog2(QDepth + 1);

    localparam logic [1:0]     CornerLast  = 2'd3;
    localparam logic [PcW-1:0] PcReset     = PcW'(1);
    localparam logic [PcW-1:0] PcMax       = PcW'(MaxPanels);

    typedef logic [CoordW-1:0] coord_t;

    // one complete panel: four corners of x, y, z and the normal flip flag
    typedef struct packed {
        coord_t [3:0][2:0] corners;
        logic              flip;
    } job_t;

    typedef struct packed {
        coord_t [2:0] normal;
        coord_t       area;
        coord_t [2:0] chord;
        coord_t       span_y;
        coord_t       span_z;
        logic         degenerate;
    } result_t;

endpackage

@@ src/qpn_front.sv @@
`timescale 1ns / 1ps
// Front end: corner store, panel count register and panel classification.
// Depends on qpn_pkg.
module qpn_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  qpn_pkg::coord_t            coord_x,
    input  qpn_pkg::coord_t            coord_y,
    input  qpn_pkg::coord_t            coord_z,
    input  logic [1:0]                 corner,
    input  logic [qpn_pkg::IdxW-1:0]   panel_index,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [qpn_pkg::PcW-1:0]    cfg_data,
    output logic                       q_push,
    output qpn_pkg::job_t              q_job,
    input  logic                       q_full
);

    qpn_pkg::coord_t [2:0][2:0] store_reg;
    logic [qpn_pkg::PcW-1:0]    pc_reg;
    logic [qpn_pkg::PcW-1:0]    pc_sat;
    logic [qpn_pkg::PcW-1:0]    half;
    logic                       accept;

    assign full      = q_full;
    assign cfg_ready = 1'b1;
    assign accept    = push && !q_full;
    assign q_push    = accept && (corner == qpn_pkg::CornerLast);

    assign pc_sat = (pc_reg > qpn_pkg::PcMax) ? qpn_pkg::PcMax : pc_reg;
    assign half   = pc_sat >> 1;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            q_job.corners[k] = store_reg[k];
        end
        q_job.corners[3][0] = coord_x;
        q_job.corners[3][1] = coord_y;
        q_job.corners[3][2] = coord_z;
        q_job.flip = {1'b0, panel_index} < half;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            pc_reg    <= qpn_pkg::PcReset;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pc_reg <= cfg_data;
            end
            if (accept && corner != qpn_pkg::CornerLast)
            begin
                store_reg[corner[1:0]] <= {coord_z, coord_y, coord_x};
            end
        end
    end

endmodule

@@ src/qpn_queue.sv @@
`timescale 1ns / 1ps
// Short panel queue between the front end and the compute sequencer.
// Depends on qpn_pkg.
module qpn_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  qpn_pkg::job_t wr_job,
    output logic          full,
    input  logic          rd_en,
    output qpn_pkg::job_t rd_job,
    output logic          valid
);

    qpn_pkg::job_t                  mem_reg [qpn_pkg::QDepth];
    logic [qpn_pkg::PtrW-1:0]       wr_ptr_reg;
    logic [qpn_pkg::PtrW-1:0]       rd_ptr_reg;
    logic [qpn_pkg::QCntW-1:0]      cnt_reg;
    logic                           do_wr;
    logic                           do_rd;

    assign full   = cnt_reg == qpn_pkg::QCntW'(qpn_pkg::QDepth);
    assign valid  = cnt_reg != '0;
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && valid;
    assign rd_job = mem_reg[rd_ptr_reg];

    function automatic logic [qpn_pkg::PtrW-1:0] bump(input logic [qpn_pkg::PtrW-1:0] p);
        bump = (p == qpn_pkg::PtrW'(qpn_pkg::QDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

@@ src/qpn_back.sv @@
`timescale 1ns / 1ps
// Compute sequencer: normalizer, shared multiplier, bit-serial square root,
// three divider lanes, area shifter and the result register. Depends on qpn_pkg.
module qpn_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  qpn_pkg::job_t     q_job,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output qpn_pkg::result_t  res
);

    typedef enum logic [3:0] {
        S_IDLE, S_NMAX, S_NORM, S_CROSS, S_SQ, S_SQRT, S_DIV, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        VEC_R1, VEC_R2, VEC_N, VEC_C, VEC_S
    } vec_t;

    typedef logic signed [36:0] wv_t;

    state_t              st_reg;
    vec_t                vec_reg;
    logic [4:0]          cnt_reg;
    wv_t  [2:0]          r2_reg, ch_reg, sp_reg;
    logic                flip_reg;
    logic [2:0]          vs_reg;
    logic [2:0][63:0]    vm_reg;
    logic [63:0]         mx_reg;
    logic signed [7:0]   sh_reg, e1_reg, e2_reg, e3_reg;
    logic [2:0][31:0]    r1s_reg, r2s_reg;
    logic signed [63:0]  prod_reg;
    logic [63:0]         acc_reg;
    logic [63:0]         rad_reg;
    logic [31:0]         root_reg;
    logic [32:0]         srem_reg;
    logic [2:0][30:0]    q_reg;
    logic [2:0][31:0]    drem_reg;
    qpn_pkg::result_t    wr_reg;
    qpn_pkg::result_t    out_reg;
    logic                ovalid_reg;

    wv_t  [3:0][2:0]     v;
    wv_t  [2:0]          r1_w, r2_w, ch_w, sp_w;
    logic [63:0]         mx01, vmax;
    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  mul_p;
    logic [63:0]         cr_d;
    logic [34:0]         sq_remw, sq_trial;
    logic                sq_ge;
    logic [32:0]         srem_next;
    logic [31:0]         root_next;
    logic [2:0][30:0]    q_next;
    logic [2:0][31:0]    drem_next;
    logic [2:0][31:0]    comp;
    logic signed [8:0]   t_sh;
    logic [8:0]          u_sh;
    logic [63:0]         area_wide;
    logic [31:0]         area_val;
    logic                area_sat;
    logic                out_free;
    logic                out_load;
    qpn_pkg::result_t    out_next;

    function automatic logic [63:0] mag64(input logic [63:0] x);
        mag64 = x[63] ? (~x + 64'd1) : x;
    endfunction

    function automatic logic [63:0] ld_mag(input wv_t w);
        ld_mag = mag64({{27{w[36]}}, w});
    endfunction

    function automatic logic [31:0] neg_if(input logic n, input logic [31:0] x);
        neg_if = n ? (~x + 32'd1) : x;
    endfunction

    // panel differences from the queue head
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v[k][i] = wv_t'($signed(q_job.corners[k][i]));
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            r1_w[i] = v[2][i] - v[0][i];
            r2_w[i] = v[1][i] - v[3][i];
            ch_w[i] = (v[1][i] - v[0][i]) + (v[2][i] - v[3][i]);
            sp_w[i] = ((v[3][i] - v[0][i]) <<< 1) + (v[3][i] - v[0][i])
                      + (v[2][i] - v[1][i]);
        end
        sp_w[0] = '0;
    end

    assign mx01 = (vm_reg[0] > vm_reg[1]) ? vm_reg[0] : vm_reg[1];
    assign vmax = (mx01 > vm_reg[2]) ? mx01 : vm_reg[2];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (st_reg == S_CROSS)
        begin
            case (cnt_reg)
                5'd0:    begin mul_a = r1s_reg[1]; mul_b = r2s_reg[2]; end
                5'd1:    begin mul_a = r1s_reg[2]; mul_b = r2s_reg[1]; end
                5'd2:    begin mul_a = r1s_reg[2]; mul_b = r2s_reg[0]; end
                5'd3:    begin mul_a = r1s_reg[0]; mul_b = r2s_reg[2]; end
                5'd4:    begin mul_a = r1s_reg[0]; mul_b = r2s_reg[1]; end
                5'd5:    begin mul_a = r1s_reg[1]; mul_b = r2s_reg[0]; end
                default: begin mul_a = '0;         mul_b = '0;         end
            endcase
        end
        else if (st_reg == S_SQ)
        begin
            case (cnt_reg)
                5'd0:    begin mul_a = vm_reg[0][31:0]; mul_b = vm_reg[0][31:0]; end
                5'd1:    begin mul_a = vm_reg[1][31:0]; mul_b = vm_reg[1][31:0]; end
                5'd2:    begin mul_a = vm_reg[2][31:0]; mul_b = vm_reg[2][31:0]; end
                default: begin mul_a = '0;              mul_b = '0;              end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;
    assign cr_d  = acc_reg - prod_reg;

    // one root bit per cycle
    assign sq_remw   = {srem_reg, rad_reg[63:62]};
    assign sq_trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge     = sq_remw >= sq_trial;
    assign srem_next = sq_ge ? 33'(sq_remw - sq_trial) : sq_remw[32:0];
    assign root_next = {root_reg[30:0], sq_ge};

    // one quotient bit per cycle in each lane; magnitude never exceeds the root
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cnt_reg == '0)
            begin
                q_next[i]    = {30'd0, vm_reg[i][31:0] >= root_reg};
                drem_next[i] = (vm_reg[i][31:0] >= root_reg)
                               ? vm_reg[i][31:0] - root_reg : vm_reg[i][31:0];
            end
            else
            begin
                q_next[i]    = {q_reg[i][29:0], {drem_reg[i], 1'b0} >= {1'b0, root_reg}};
                drem_next[i] = ({drem_reg[i], 1'b0} >= {1'b0, root_reg})
                               ? 32'({drem_reg[i], 1'b0} - {1'b0, root_reg})
                               : drem_reg[i][30:0] << 1;
                if ({drem_reg[i], 1'b0} < {1'b0, root_reg})
                begin
                    drem_next[i] = {drem_reg[i][30:0], 1'b0};
                end
            end
            comp[i] = neg_if(vs_reg[i], {1'b0, q_next[i]});
        end
    end

    // area = root scaled back by all normalizing shifts, halved, Q32.32 to Q16.16
    always_comb
    begin
        t_sh      = 9'(e1_reg) + 9'(e2_reg) + 9'(e3_reg) + 9'sd17;
        u_sh      = 9'(-t_sh);
        area_wide = '0;
        area_val  = '0;
        area_sat  = 1'b0;
        if (t_sh >= 9'sd32)
        begin
            area_val = '0;
        end
        else if (t_sh >= 9'sd0)
        begin
            area_val = root_reg >> t_sh[4:0];
        end
        else if (u_sh >= 9'd32)
        begin
            area_sat = 1'b1;
        end
        else
        begin
            area_wide = {32'd0, root_reg} << u_sh[4:0];
            area_sat  = area_wide[63:32] != '0;
            area_val  = area_wide[31:0];
        end
        if (area_sat)
        begin
            area_val = '1;
        end
    end

    // apply the half-of-panels sign to normal and span on the way out
    always_comb
    begin
        out_next = wr_reg;
        for (int i = 0; i < 3; i++)
        begin
            out_next.normal[i] = neg_if(flip_reg, wr_reg.normal[i]);
        end
        out_next.span_y = neg_if(!flip_reg, wr_reg.span_y);
        out_next.span_z = neg_if(!flip_reg, wr_reg.span_z);
    end

    assign q_pop    = (st_reg == S_IDLE) && q_valid;
    assign empty    = !ovalid_reg;
    assign res      = out_reg;
    assign out_free = !ovalid_reg || pop;
    assign out_load = (st_reg == S_DONE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            vec_reg    <= VEC_R1;
            cnt_reg    <= '0;
            r2_reg     <= '0;
            ch_reg     <= '0;
            sp_reg     <= '0;
            flip_reg   <= 1'b0;
            vs_reg     <= '0;
            vm_reg     <= '0;
            mx_reg     <= '0;
            sh_reg     <= '0;
            e1_reg     <= '0;
            e2_reg     <= '0;
            e3_reg     <= '0;
            r1s_reg    <= '0;
            r2s_reg    <= '0;
            prod_reg   <= '0;
            acc_reg    <= '0;
            rad_reg    <= '0;
            root_reg   <= '0;
            srem_reg   <= '0;
            q_reg      <= '0;
            drem_reg   <= '0;
            wr_reg     <= '0;
            out_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (pop && ovalid_reg)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        r2_reg   <= r2_w;
                        ch_reg   <= ch_w;
                        sp_reg   <= sp_w;
                        flip_reg <= q_job.flip;
                        wr_reg   <= '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            vs_reg[i] <= r1_w[i][36];
                            vm_reg[i] <= ld_mag(r1_w[i]);
                        end
                        vec_reg <= VEC_R1;
                        st_reg  <= S_NMAX;
                    end
                end
                S_NMAX:
                begin
                    mx_reg <= vmax;
                    sh_reg <= '0;
                    if (vmax != '0)
                    begin
                        st_reg <= S_NORM;
                    end
                    else if (vec_reg == VEC_S)
                    begin
                        wr_reg.degenerate <= 1'b1;
                        st_reg            <= S_DONE;
                    end
                    else if (vec_reg == VEC_C)
                    begin
                        // zero chord: keep zeros, move on to the span vector
                        wr_reg.degenerate <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            vs_reg[i] <= sp_reg[i][36];
                            vm_reg[i] <= ld_mag(sp_reg[i]);
                        end
                        vec_reg <= VEC_S;
                    end
                    else
                    begin
                        // zero diagonal or zero normal: normal and area stay zero
                        wr_reg.degenerate <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            vs_reg[i] <= ch_reg[i][36];
                            vm_reg[i] <= ld_mag(ch_reg[i]);
                        end
                        vec_reg <= VEC_C;
                    end
                end
                S_NORM:
                begin
                    if (mx_reg[63:31] != '0)
                    begin
                        mx_reg <= mx_reg >> 1;
                        sh_reg <= sh_reg - 8'sd1;
                        for (int i = 0; i < 3; i++)
                        begin
                            vm_reg[i] <= vm_reg[i] >> 1;
                        end
                    end
                    else if (!mx_reg[30])
                    begin
                        mx_reg <= mx_reg << 1;
                        sh_reg <= sh_reg + 8'sd1;
                        for (int i = 0; i < 3; i++)
                        begin
                            vm_reg[i] <= vm_reg[i] << 1;
                        end
                    end
                    else
                    begin
                        cnt_reg <= '0;
                        unique case (vec_reg)
                            VEC_R1:
                            begin
                                e1_reg <= sh_reg;
                                for (int i = 0; i < 3; i++)
                                begin
                                    r1s_reg[i] <= neg_if(vs_reg[i], vm_reg[i][31:0]);
                                    vs_reg[i]  <= r2_reg[i][36];
                                    vm_reg[i]  <= ld_mag(r2_reg[i]);
                                end
                                vec_reg <= VEC_R2;
                                st_reg  <= S_NMAX;
                            end
                            VEC_R2:
                            begin
                                e2_reg <= sh_reg;
                                for (int i = 0; i < 3; i++)
                                begin
                                    r2s_reg[i] <= neg_if(vs_reg[i], vm_reg[i][31:0]);
                                end
                                st_reg <= S_CROSS;
                            end
                            VEC_N:
                            begin
                                e3_reg <= sh_reg;
                                st_reg <= S_SQ;
                            end
                            default:
                            begin
                                st_reg <= S_SQ;
                            end
                        endcase
                    end
                end
                S_CROSS:
                begin
                    prod_reg <= mul_p;
                    cnt_reg  <= cnt_reg + 5'd1;
                    case (cnt_reg)
                        5'd1, 5'd3, 5'd5:
                        begin
                            acc_reg <= prod_reg;
                        end
                        5'd2:
                        begin
                            vs_reg[0] <= cr_d[63];
                            vm_reg[0] <= mag64(cr_d);
                        end
                        5'd4:
                        begin
                            vs_reg[1] <= cr_d[63];
                            vm_reg[1] <= mag64(cr_d);
                        end
                        5'd6:
                        begin
                            vs_reg[2] <= cr_d[63];
                            vm_reg[2] <= mag64(cr_d);
                            vec_reg   <= VEC_N;
                            st_reg    <= S_NMAX;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SQ:
                begin
                    prod_reg <= mul_p;
                    if (cnt_reg != 5'd3)
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                    case (cnt_reg)
                        5'd1:
                        begin
                            acc_reg <= prod_reg;
                        end
                        5'd2:
                        begin
                            acc_reg <= acc_reg + prod_reg;
                        end
                        5'd3:
                        begin
                            rad_reg  <= acc_reg + prod_reg;
                            root_reg <= '0;
                            srem_reg <= '0;
                            cnt_reg  <= '0;
                            st_reg   <= S_SQRT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SQRT:
                begin
                    rad_reg  <= rad_reg << 2;
                    srem_reg <= srem_next;
                    root_reg <= root_next;
                    if (cnt_reg == 5'd31)
                    begin
                        cnt_reg <= '0;
                        st_reg  <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_DIV:
                begin
                    q_reg    <= q_next;
                    drem_reg <= drem_next;
                    if (cnt_reg != 5'd30)
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                    else
                    begin
                        cnt_reg <= '0;
                        unique case (vec_reg)
                            VEC_N:
                            begin
                                wr_reg.normal <= comp;
                                wr_reg.area   <= area_val;
                                if (area_sat)
                                begin
                                    wr_reg.degenerate <= 1'b1;
                                end
                                for (int i = 0; i < 3; i++)
                                begin
                                    vs_reg[i] <= ch_reg[i][36];
                                    vm_reg[i] <= ld_mag(ch_reg[i]);
                                end
                                vec_reg <= VEC_C;
                                st_reg  <= S_NMAX;
                            end
                            VEC_C:
                            begin
                                wr_reg.chord <= comp;
                                for (int i = 0; i < 3; i++)
                                begin
                                    vs_reg[i] <= sp_reg[i][36];
                                    vm_reg[i] <= ld_mag(sp_reg[i]);
                                end
                                vec_reg <= VEC_S;
                                st_reg  <= S_NMAX;
                            end
                            default:
                            begin
                                wr_reg.span_y <= comp[1];
                                wr_reg.span_z <= comp[2];
                                st_reg        <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DONE:
                begin
                    // hold the finished panel until the result register frees up
                    if (out_free)
                    begin
                        out_reg <= out_next;
                        st_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/quad_panel_normal_area_tangents_unit.sv @@
`timescale 1ns / 1ps
// Top level of the quad panel normal, area and tangent unit.
// Depends on qpn_pkg, qpn_front, qpn_queue and qpn_back.
//
//   channel   | handshake            | payload
//   ----------+----------------------+----------------------------------------
//   corner in | push / full          | coord_x/y/z, corner, panel_index
//   result    | pop / empty          | normal_x/y/z, panel_area, chord_tan_x/y/z,
//             |                      | span_tan_y/z, degenerate
//   config    | cfg_valid / cfg_ready| cfg_data (panel_count)
//
// Corners 0 to 2 go to the corner store. Corner 3 queues a panel; the
// sequencer then runs the one-bit-per-cycle normalizer, the 32-step square
// root and the 31-step divider lanes for the normal, chord and span vectors.
// A zero-length vector skips its root and divide; an all-zero panel skips them all.
// Reset clears the corner store and sets panel_count to 1. Up to two panels wait
// in the queue and one result in the output register; full rises when the queue fills.
module quad_panel_normal_area_tangents_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic signed [31:0]       coord_x,
    input  logic signed [31:0]       coord_y,
    input  logic signed [31:0]       coord_z,
    input  logic [1:0]               corner,
    input  logic [15:0]              panel_index,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [31:0]       normal_x,
    output logic signed [31:0]       normal_y,
    output logic signed [31:0]       normal_z,
    output logic [31:0]              panel_area,
    output logic signed [31:0]       chord_tan_x,
    output logic signed [31:0]       chord_tan_y,
    output logic signed [31:0]       chord_tan_z,
    output logic signed [31:0]       span_tan_y,
    output logic signed [31:0]       span_tan_z,
    output logic                     degenerate,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [16:0]              cfg_data
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    qpn_pkg::job_t    wr_job;
    qpn_pkg::job_t    rd_job;
    qpn_pkg::result_t res;

    qpn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .corner      (corner),
        .panel_index (panel_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_push      (q_push),
        .q_job       (wr_job),
        .q_full      (q_full)
    );

    qpn_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_job (wr_job),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_job (rd_job),
        .valid  (q_valid)
    );

    qpn_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (rd_job),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign normal_x    = res.normal[0];
    assign normal_y    = res.normal[1];
    assign normal_z    = res.normal[2];
    assign panel_area  = res.area;
    assign chord_tan_x = res.chord[0];
    assign chord_tan_y = res.chord[1];
    assign chord_tan_z = res.chord[2];
    assign span_tan_y  = res.span_y;
    assign span_tan_z  = res.span_z;
    assign degenerate  = res.degenerate;

endmodule
